@@ rtl/core/video_unit_cpu_register_port_top_macros.svh @@
// Assertion macros for the checker file.
`ifndef VIDEO_UNIT_CPU_REGISTER_PORT_TOP_MACROS_SVH
`define VIDEO_UNIT_CPU_REGISTER_PORT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define VUCRP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vucrp check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define VUCRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vucrp check failed");

`endif

@@ rtl/core/vucrp_pkg.sv @@
package vucrp_pkg;

    // Memory sizes
    localparam int NAMETABLE_BYTES = 2048;
    localparam int PATTERN_BYTES   = 8192;
    localparam int SPRITE_BYTES    = 256;
    localparam int PALETTE_BYTES   = 32;

    // Result buffer
    localparam int OUT_DEPTH = 3;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Register bit positions
    localparam int CTRL_INC32_BIT  = 2;
    localparam int CTRL_NMI_BIT    = 7;
    localparam int STAT_VBLANK_BIT = 7;

    // Address latch masks
    localparam logic [15:0] T_CTRL_MASK    = 16'hF3FF;
    localparam logic [15:0] T_SCROLL1_MASK = 16'hFFE0;
    localparam logic [15:0] T_SCROLL2_MASK = 16'h0C1F;
    localparam logic [15:0] T_ADDR1_MASK   = 16'h00FF;
    localparam logic [15:0] T_ADDR2_MASK   = 16'hFF00;

    localparam logic [7:0]  STATUS_RESET   = 8'hA0;
    localparam logic [7:0]  STATUS_PRE_RENDER_MASK = 8'h1F;
    localparam logic [15:0] VADDR_STEP_1   = 16'd1;
    localparam logic [15:0] VADDR_STEP_32  = 16'd32;

    // Video address map (14-bit space)
    localparam logic [13:0] NT_BASE  = 14'h2000;
    localparam logic [13:0] PAL_BASE = 14'h3F00;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_VBL_SET = 2'd2,
        CMD_VBL_CLR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CTRL    = 3'd0,
        REG_MASK    = 3'd1,
        REG_STATUS  = 3'd2,
        REG_OAMADDR = 3'd3,
        REG_OAMDATA = 3'd4,
        REG_SCROLL  = 3'd5,
        REG_ADDR    = 3'd6,
        REG_DATA    = 3'd7
    } reg_idx_t;

    // What the second stage does with open bus and the read buffer
    typedef enum logic [2:0] {
        OB_KEEP   = 3'd0,
        OB_LOAD   = 3'd1,
        OB_STATUS = 3'd2,
        OB_OAM    = 3'd3,
        OB_CHR    = 3'd4,
        OB_NT     = 3'd5,
        OB_PAL    = 3'd6
    } ob_op_t;

    typedef struct packed {
        ob_op_t     op;
        logic [7:0] data;
        logic       nmi;
    } stage_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi;
    } result_t;

    // Physical name-table offset for a video address at or above NT_BASE
    function automatic logic [10:0] nt_offset(input logic [13:0] addr, input logic mode);
        logic bank;
        bank = mode ? addr[11] : addr[10];
        return {bank, addr[9:0]};
    endfunction

    // Palette index with the backdrop mirrors folded down
    function automatic logic [4:0] pal_index(input logic [13:0] addr);
        logic [4:0] p;
        p = addr[4:0];
        if (p[1:0] == 2'b00)
        begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

endpackage

@@ rtl/core/video_unit_cpu_register_port_top.sv @@
// Channel   | Signals                             | Contents (low bit first)
// ----------+-------------------------------------+-------------------------------------
// cpu in    | s_axis_tvalid/tready/tdata/tuser    | tdata: write_data; tuser: command,
//           |                                     |        reg_index
// result    | m_axis_tvalid/tready/tdata          | tdata: read_data, nmi_request, zeros
// config    | cfg_we, cfg_wdata                   | mirroring_mode
//
// One CPU transaction per cycle while s_axis_tready is high. Stage 1 updates the latches and
// issues the memory accesses (a palette read uses the name-table and palette RAMs); stage 2
// takes the registered RAM data, updates open bus and the read buffer, and pushes the result.
// After reset a clearing pass zeroes all RAMs, one entry per cycle over the largest depth,
// s_axis_tready low throughout. A 3-entry result buffer absorbs m_axis stalls; s_axis_tready
// otherwise drops only when that buffer plus the transaction in stage 2 fill it.
module video_unit_cpu_register_port_top #(
    parameter int NAMETABLE_BYTES = vucrp_pkg::NAMETABLE_BYTES,
    parameter int PATTERN_BYTES   = vucrp_pkg::PATTERN_BYTES,
    parameter int SPRITE_BYTES    = vucrp_pkg::SPRITE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // mirroring_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_data
    input  logic [4:0]  s_axis_tuser,   // [1:0] command, [4:2] reg_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] nmi_request, [15:9] zero
);

    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int CHR_AW = $clog2(PATTERN_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);
    localparam int PAL_AW = $clog2(vucrp_pkg::PALETTE_BYTES);
    localparam int MAX_A  = (PATTERN_BYTES > NAMETABLE_BYTES) ? PATTERN_BYTES : NAMETABLE_BYTES;
    localparam int MAX_B  = (SPRITE_BYTES > vucrp_pkg::PALETTE_BYTES) ?
                            SPRITE_BYTES : vucrp_pkg::PALETTE_BYTES;
    localparam int CLR_DEPTH = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);
    localparam logic [vucrp_pkg::OUT_CNT_W:0] OCC_LIMIT =
        (vucrp_pkg::OUT_CNT_W + 1)'(vucrp_pkg::OUT_DEPTH - 1);

    // Architectural state
    logic        mode_reg;
    logic [15:0] v_reg, v_next;
    logic [15:0] t_reg, t_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  oamaddr_reg, oamaddr_next;
    logic [7:0]  open_bus_reg, open_bus_next;
    logic [7:0]  rbuf_reg, rbuf_next;

    // Clearing pass
    logic             clearing_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    // Stage 2
    logic              p_valid_reg;
    vucrp_pkg::stage_t p_reg, p_next;

    // Input decode
    logic                in_acc;
    vucrp_pkg::cmd_t     cmd;
    vucrp_pkg::reg_idx_t ridx;
    logic [7:0]          wd;
    logic [13:0]         vaddr;
    logic [15:0]         v_inc;
    logic [15:0]         t_addr2;

    // Item memory requests
    logic chr_en, chr_we, nt_en, nt_we, spr_en, spr_we, pal_en, pal_we;

    // RAM ports
    logic              chr_ram_en, chr_ram_we, nt_ram_en, nt_ram_we;
    logic              spr_ram_en, spr_ram_we, pal_ram_en, pal_ram_we;
    logic [CHR_AW-1:0] chr_addr;
    logic [NT_AW-1:0]  nt_addr;
    logic [SPR_AW-1:0] spr_addr;
    logic [PAL_AW-1:0] pal_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        chr_rdata, nt_rdata, spr_rdata, pal_rdata;

    // Result buffer
    vucrp_pkg::result_t              res;
    vucrp_pkg::result_t              head;
    logic                            fifo_not_empty;
    logic [vucrp_pkg::OUT_CNT_W-1:0] fifo_count;
    logic [vucrp_pkg::OUT_CNT_W:0]   occupancy;

    assign occupancy     = {1'b0, fifo_count} + {{vucrp_pkg::OUT_CNT_W{1'b0}}, p_valid_reg};
    assign s_axis_tready = !clearing_reg && (occupancy <= OCC_LIMIT);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cmd           = vucrp_pkg::cmd_t'(s_axis_tuser[1:0]);
    assign ridx          = vucrp_pkg::reg_idx_t'(s_axis_tuser[4:2]);
    assign wd            = s_axis_tdata;
    assign vaddr         = v_reg[13:0];
    assign v_inc         = v_reg + (ctrl_reg[vucrp_pkg::CTRL_INC32_BIT] ?
                                    vucrp_pkg::VADDR_STEP_32 : vucrp_pkg::VADDR_STEP_1);
    assign t_addr2       = (t_reg & vucrp_pkg::T_ADDR2_MASK) | {8'b0, wd};

    // Stage 1: register and latch updates, memory request
    always_comb
    begin
        v_next       = v_reg;
        t_next       = t_reg;
        fine_x_next  = fine_x_reg;
        toggle_next  = toggle_reg;
        ctrl_next    = ctrl_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        oamaddr_next = oamaddr_reg;
        chr_en = 1'b0; chr_we = 1'b0;
        nt_en  = 1'b0; nt_we  = 1'b0;
        spr_en = 1'b0; spr_we = 1'b0;
        pal_en = 1'b0; pal_we = 1'b0;
        p_next.op   = vucrp_pkg::OB_KEEP;
        p_next.data = wd;
        p_next.nmi  = 1'b0;
        if (in_acc)
        begin
            unique case (cmd)
                vucrp_pkg::CMD_READ:
                begin
                    unique case (ridx)
                        vucrp_pkg::REG_STATUS:
                        begin
                            p_next.op   = vucrp_pkg::OB_STATUS;
                            p_next.data = status_reg;
                            status_next[vucrp_pkg::STAT_VBLANK_BIT] = 1'b0;
                            toggle_next = 1'b0;
                        end
                        vucrp_pkg::REG_OAMDATA:
                        begin
                            p_next.op = vucrp_pkg::OB_OAM;
                            spr_en    = 1'b1;
                        end
                        vucrp_pkg::REG_DATA:
                        begin
                            v_next = v_inc;
                            if (vaddr < vucrp_pkg::NT_BASE)
                            begin
                                p_next.op = vucrp_pkg::OB_CHR;
                                chr_en    = 1'b1;
                            end
                            else if (vaddr < vucrp_pkg::PAL_BASE)
                            begin
                                p_next.op = vucrp_pkg::OB_NT;
                                nt_en     = 1'b1;
                            end
                            else
                            begin
                                p_next.op = vucrp_pkg::OB_PAL;
                                nt_en     = 1'b1;
                                pal_en    = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                vucrp_pkg::CMD_WRITE:
                begin
                    p_next.op = vucrp_pkg::OB_LOAD;
                    unique case (ridx)
                        vucrp_pkg::REG_CTRL:
                        begin
                            t_next     = (t_reg & vucrp_pkg::T_CTRL_MASK) | {4'b0, wd[1:0], 10'b0};
                            ctrl_next  = wd;
                            p_next.nmi = status_reg[vucrp_pkg::STAT_VBLANK_BIT]
                                         && !ctrl_reg[vucrp_pkg::CTRL_NMI_BIT]
                                         && wd[vucrp_pkg::CTRL_NMI_BIT];
                        end
                        vucrp_pkg::REG_MASK:
                        begin
                            mask_next = wd;
                        end
                        vucrp_pkg::REG_OAMADDR:
                        begin
                            oamaddr_next = wd;
                        end
                        vucrp_pkg::REG_OAMDATA:
                        begin
                            spr_en       = 1'b1;
                            spr_we       = 1'b1;
                            oamaddr_next = oamaddr_reg + 1'b1;
                        end
                        vucrp_pkg::REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                t_next      = (t_reg & vucrp_pkg::T_SCROLL1_MASK) | {11'b0, wd[7:3]};
                                fine_x_next = wd[2:0];
                                toggle_next = 1'b1;
                            end
                            else
                            begin
                                t_next      = (t_reg & vucrp_pkg::T_SCROLL2_MASK)
                                              | {1'b0, wd[2:0], 2'b0, wd[7:3], 5'b0};
                                toggle_next = 1'b0;
                            end
                        end
                        vucrp_pkg::REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                t_next      = (t_reg & vucrp_pkg::T_ADDR1_MASK) | {2'b0, wd[5:0], 8'b0};
                                toggle_next = 1'b1;
                            end
                            else
                            begin
                                t_next      = t_addr2;
                                v_next      = t_addr2;
                                toggle_next = 1'b0;
                            end
                        end
                        vucrp_pkg::REG_DATA:
                        begin
                            v_next = v_inc;
                            if (vaddr < vucrp_pkg::NT_BASE)
                            begin
                                chr_en = 1'b1;
                                chr_we = 1'b1;
                            end
                            else if (vaddr < vucrp_pkg::PAL_BASE)
                            begin
                                nt_en = 1'b1;
                                nt_we = 1'b1;
                            end
                            else
                            begin
                                pal_en = 1'b1;
                                pal_we = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                vucrp_pkg::CMD_VBL_SET:
                begin
                    p_next.nmi = !status_reg[vucrp_pkg::STAT_VBLANK_BIT]
                                 && ctrl_reg[vucrp_pkg::CTRL_NMI_BIT];
                    status_next[vucrp_pkg::STAT_VBLANK_BIT] = 1'b1;
                end
                vucrp_pkg::CMD_VBL_CLR:
                begin
                    status_next = status_reg & vucrp_pkg::STATUS_PRE_RENDER_MASK;
                end
                default:
                begin
                end
            endcase
        end
    end

    // RAM port muxing: the clearing pass owns all ports until it ends
    always_comb
    begin
        ram_wdata  = clearing_reg ? 8'h00 : wd;
        chr_ram_en = clearing_reg || chr_en;
        chr_ram_we = clearing_reg || chr_we;
        nt_ram_en  = clearing_reg || nt_en;
        nt_ram_we  = clearing_reg || nt_we;
        spr_ram_en = clearing_reg || spr_en;
        spr_ram_we = clearing_reg || spr_we;
        pal_ram_en = clearing_reg || pal_en;
        pal_ram_we = clearing_reg || pal_we;
        chr_addr   = clearing_reg ? clr_cnt_reg[CHR_AW-1:0] : vaddr[CHR_AW-1:0];
        nt_addr    = clearing_reg ? clr_cnt_reg[NT_AW-1:0]
                                  : NT_AW'(vucrp_pkg::nt_offset(vaddr, mode_reg));
        spr_addr   = clearing_reg ? clr_cnt_reg[SPR_AW-1:0] : oamaddr_reg[SPR_AW-1:0];
        pal_addr   = clearing_reg ? clr_cnt_reg[PAL_AW-1:0]
                                  : PAL_AW'(vucrp_pkg::pal_index(vaddr));
    end

    // Stage 2: open bus and read buffer from registered RAM data
    always_comb
    begin
        open_bus_next = open_bus_reg;
        rbuf_next     = rbuf_reg;
        if (p_valid_reg)
        begin
            unique case (p_reg.op)
                vucrp_pkg::OB_KEEP:
                begin
                end
                vucrp_pkg::OB_LOAD:
                begin
                    open_bus_next = p_reg.data;
                end
                vucrp_pkg::OB_STATUS:
                begin
                    open_bus_next = {p_reg.data[7:5], open_bus_reg[4:0]};
                end
                vucrp_pkg::OB_OAM:
                begin
                    open_bus_next = spr_rdata;
                end
                vucrp_pkg::OB_CHR:
                begin
                    open_bus_next = rbuf_reg;
                    rbuf_next     = chr_rdata;
                end
                vucrp_pkg::OB_NT:
                begin
                    open_bus_next = rbuf_reg;
                    rbuf_next     = nt_rdata;
                end
                vucrp_pkg::OB_PAL:
                begin
                    open_bus_next = pal_rdata;
                    rbuf_next     = nt_rdata;
                end
                default:
                begin
                end
            endcase
        end
        res.read_data = open_bus_next;
        res.nmi       = p_reg.nmi;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            v_reg        <= '0;
            t_reg        <= '0;
            fine_x_reg   <= '0;
            toggle_reg   <= 1'b0;
            ctrl_reg     <= '0;
            mask_reg     <= '0;
            status_reg   <= vucrp_pkg::STATUS_RESET;
            oamaddr_reg  <= '0;
            open_bus_reg <= '0;
            rbuf_reg     <= '0;
            p_valid_reg  <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            v_reg        <= v_next;
            t_reg        <= t_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            oamaddr_reg  <= oamaddr_next;
            open_bus_reg <= open_bus_next;
            rbuf_reg     <= rbuf_next;
            p_valid_reg  <= in_acc;
            if (clearing_reg)
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_reg <= p_next;
        end
    end

    vucrp_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_chr_ram (
        .clk   (clk),
        .en    (chr_ram_en),
        .we    (chr_ram_we),
        .addr  (chr_addr),
        .wdata (ram_wdata),
        .rdata (chr_rdata)
    );

    vucrp_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt_ram (
        .clk   (clk),
        .en    (nt_ram_en),
        .we    (nt_ram_we),
        .addr  (nt_addr),
        .wdata (ram_wdata),
        .rdata (nt_rdata)
    );

    vucrp_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_spr_ram (
        .clk   (clk),
        .en    (spr_ram_en),
        .we    (spr_ram_we),
        .addr  (spr_addr),
        .wdata (ram_wdata),
        .rdata (spr_rdata)
    );

    vucrp_ram #(.WIDTH(8), .DEPTH(vucrp_pkg::PALETTE_BYTES)) u_pal_ram (
        .clk   (clk),
        .en    (pal_ram_en),
        .we    (pal_ram_we),
        .addr  (pal_addr),
        .wdata (ram_wdata),
        .rdata (pal_rdata)
    );

    vucrp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p_valid_reg),
        .push_data (res),
        .pop       (m_axis_tready),
        .not_empty (fifo_not_empty),
        .head_data (head),
        .count     (fifo_count)
    );

    assign m_axis_tvalid = fifo_not_empty;
    assign m_axis_tdata  = {7'b0, head.nmi, head.read_data};

endmodule

@@ rtl/core/vucrp_ram.sv @@
module vucrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/vucrp_out_fifo.sv @@
module vucrp_out_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  vucrp_pkg::result_t                  push_data,
    input  logic                                pop,
    output logic                                not_empty,
    output vucrp_pkg::result_t                  head_data,
    output logic [vucrp_pkg::OUT_CNT_W-1:0]     count
);

    localparam int PTR_W = $clog2(vucrp_pkg::OUT_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(vucrp_pkg::OUT_DEPTH - 1);

    vucrp_pkg::result_t              buf_reg [vucrp_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]                head_reg, head_next;
    logic [PTR_W-1:0]                tail_reg, tail_next;
    logic [vucrp_pkg::OUT_CNT_W-1:0] count_reg, count_next;
    logic                            do_pop;

    // Pointer and fill update; push never arrives when full
    always_comb
    begin
        do_pop     = pop && (count_reg != '0);
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[tail_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_data = buf_reg[head_reg];
    assign count     = count_reg;

endmodule

@@ rtl/core/vucrp_checker.sv @@
`include "video_unit_cpu_register_port_top_macros.svh"

module vucrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic last_nmi_reg;
    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // NMI flag of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_nmi_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            last_nmi_reg <= m_axis_tdata[8];
        end
    end

    // Stalled result holds
    `VUCRP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `VUCRP_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // No result appears without an accepted transaction ahead of it
    `VUCRP_ASSERT_NEXT(a_no_spurious, !m_axis_tvalid && !$past(in_acc), !m_axis_tvalid)

    // NMI needs a non-NMI transaction in between to re-arm
    `VUCRP_ASSERT_SAME(a_nmi_rearm, m_axis_tvalid && m_axis_tready && m_axis_tdata[8], !last_nmi_reg)

endmodule

bind video_unit_cpu_register_port_top vucrp_checker u_vucrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/video_unit_cpu_register_port_top_test.sv @@
module video_unit_cpu_register_port_top_test;

    // No transaction on either side for this long means the block is hung.
    // Covers the RAM clearing pass after reset plus the long receiver hold.
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 37;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] write_data
    logic [4:0]  s_axis_tuser;   // [1:0] command, [4:2] reg_index
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] read_data, [8] nmi_request

    video_unit_cpu_register_port_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the register port state
    logic        mir_horizontal;
    logic [15:0] vaddr;
    logic [15:0] taddr;
    logic [2:0]  fine_x;
    logic        second_write;
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  status_q;
    logic [7:0]  oam_ptr;
    logic [7:0]  data_latch;
    logic [7:0]  bus_latch;
    logic [7:0]  pal_ram [32];
    logic [7:0]  oam_ram [256];
    logic [7:0]  nt_ram  [2048];
    logic [7:0]  chr_ram [8192];

    vucrp_pkg::result_t pending_bus_results[$];

    int  err_count;
    int  stall_cycles;
    bit  src_idle_on;
    bit  sink_idle_on;
    bit  hold_pending;
    int  hold_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Physical name-table slot for a 14-bit video address in 0x2000-0x3FFF
    function automatic int nt_index(input logic [13:0] a);
        logic [1:0] quad;
        logic       bank;
        quad = a[11:10];
        bank = mir_horizontal ? quad[1] : quad[0];
        return int'(bank) * 1024 + int'(a[9:0]);
    endfunction

    // Palette slot; the backdrop entries of the sprite half fold onto the background half
    function automatic int pal_slot(input logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if ((p & 5'h13) == 5'h10)
        begin
            p = p - 5'h10;
        end
        return int'(p);
    endfunction

    task automatic step_vaddr();
        vaddr = vaddr + (ctrl_q[2] ? 16'd32 : 16'd1);
    endtask

    // Expected bus value and NMI for one CPU transaction; updates the shadow state
    task automatic predict_bus_access(input vucrp_pkg::cmd_t c, input vucrp_pkg::reg_idx_t r,
                                      input logic [7:0] d, output vucrp_pkg::result_t res);
        logic       nmi;
        logic [13:0] a;
        logic [7:0] rv;
        nmi = 1'b0;
        a = vaddr[13:0];
        case (c)
            vucrp_pkg::CMD_READ:
            begin
                case (r)
                    vucrp_pkg::REG_STATUS:
                    begin
                        rv = {status_q[7:5], bus_latch[4:0]};
                        status_q[7] = 1'b0;
                        second_write = 1'b0;
                        bus_latch = rv;
                    end
                    vucrp_pkg::REG_OAMDATA: bus_latch = oam_ram[oam_ptr];
                    vucrp_pkg::REG_DATA:
                    begin
                        if (a < 14'h2000)
                        begin
                            rv = data_latch;
                            data_latch = chr_ram[a[12:0]];
                        end
                        else if (a < 14'h3F00)
                        begin
                            rv = data_latch;
                            data_latch = nt_ram[nt_index(a)];
                        end
                        else
                        begin
                            // palette comes back at once, buffer takes the name table below
                            data_latch = nt_ram[nt_index(a)];
                            rv = pal_ram[pal_slot(a)];
                        end
                        bus_latch = rv;
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            vucrp_pkg::CMD_WRITE:
            begin
                bus_latch = d;
                case (r)
                    vucrp_pkg::REG_CTRL:
                    begin
                        nmi = status_q[7] && !ctrl_q[7] && d[7];
                        taddr = (taddr & 16'hF3FF) | {4'h0, d[1:0], 10'h000};
                        ctrl_q = d;
                    end
                    vucrp_pkg::REG_MASK: mask_q = d;
                    vucrp_pkg::REG_OAMADDR: oam_ptr = d;
                    vucrp_pkg::REG_OAMDATA:
                    begin
                        oam_ram[oam_ptr] = d;
                        oam_ptr = oam_ptr + 8'd1;
                    end
                    vucrp_pkg::REG_SCROLL:
                    begin
                        if (!second_write)
                        begin
                            taddr = (taddr & 16'hFFE0) | {11'h000, d[7:3]};
                            fine_x = d[2:0];
                        end
                        else
                        begin
                            taddr = (taddr & 16'h0C1F) | {6'h00, d[7:3], 5'h00}
                                    | {1'b0, d[2:0], 12'h000};
                        end
                        second_write = !second_write;
                    end
                    vucrp_pkg::REG_ADDR:
                    begin
                        if (!second_write)
                        begin
                            taddr = {2'b00, d[5:0], taddr[7:0]};
                        end
                        else
                        begin
                            taddr = {taddr[15:8], d};
                            vaddr = taddr;
                        end
                        second_write = !second_write;
                    end
                    vucrp_pkg::REG_DATA:
                    begin
                        if (a < 14'h2000)
                        begin
                            chr_ram[a[12:0]] = d;
                        end
                        else if (a < 14'h3F00)
                        begin
                            nt_ram[nt_index(a)] = d;
                        end
                        else
                        begin
                            pal_ram[pal_slot(a)] = d;
                        end
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            vucrp_pkg::CMD_VBL_SET:
            begin
                nmi = !status_q[7] && ctrl_q[7];
                status_q[7] = 1'b1;
            end
            default: status_q = status_q & 8'h1F;
        endcase
        res.read_data = bus_latch;
        res.nmi = nmi;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %02h want %02h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Send one CPU transaction, with random idle cycles ahead of it
    task automatic issue_cpu_access(input vucrp_pkg::cmd_t c, input vucrp_pkg::reg_idx_t r,
                                    input logic [7:0] d);
        vucrp_pkg::result_t res;
        while (src_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= {r, c};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predict_bus_access(c, r, d, res);
        pending_bus_results.push_back(res);
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic wait_bus_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_bus_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mirroring(input logic horiz);
        cfg_we    <= 1'b1;
        cfg_wdata <= horiz;
        @(posedge clk);
        cfg_we <= 1'b0;
        mir_horizontal = horiz;
    endtask

    task automatic set_vram_pointer(input logic [13:0] a, input logic [1:0] junk);
        issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_ADDR, {junk, a[13:8]});
        issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_ADDR, a[7:0]);
    endtask

    // Open bus, status, NMI rules, OAM wrap, palette mirrors, name-table mirror, buffered reads
    task automatic test_register_corners();
        issue_cpu_access(vucrp_pkg::CMD_READ,    vucrp_pkg::REG_CTRL,    8'hFF);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_STATUS,  8'hFF);
        issue_cpu_access(vucrp_pkg::CMD_READ,    vucrp_pkg::REG_STATUS,  8'h00);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_CTRL,    8'h80);  // no nmi
        issue_cpu_access(vucrp_pkg::CMD_VBL_SET, vucrp_pkg::REG_CTRL,    8'h00);  // nmi
        issue_cpu_access(vucrp_pkg::CMD_VBL_SET, vucrp_pkg::REG_DATA,    8'hFF);  // none
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_CTRL,    8'h00);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_CTRL,    8'h87);  // nmi
        issue_cpu_access(vucrp_pkg::CMD_VBL_CLR, vucrp_pkg::REG_STATUS,  8'h00);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_MASK,    8'h1E);
        issue_cpu_access(vucrp_pkg::CMD_READ,    vucrp_pkg::REG_MASK,    8'h00);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_OAMADDR, 8'hFF);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_OAMDATA, 8'h5A);  // wraps to 0
        issue_cpu_access(vucrp_pkg::CMD_READ,    vucrp_pkg::REG_OAMDATA, 8'h00);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_SCROLL,  8'hFF);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_SCROLL,  8'hFF);
        set_vram_pointer(14'h3F10, 2'b11);                  // sprite backdrop mirror
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_DATA,    8'h3C);  // step 32
        issue_cpu_access(vucrp_pkg::CMD_READ,    vucrp_pkg::REG_DATA,    8'h00);  // 0x3F30
        set_vram_pointer(14'h3000, 2'b00);                  // name-table mirror region
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_DATA,    8'hA5);
        issue_cpu_access(vucrp_pkg::CMD_WRITE,   vucrp_pkg::REG_CTRL,    8'h00);
        set_vram_pointer(14'h2000, 2'b00);
        issue_cpu_access(vucrp_pkg::CMD_READ,    vucrp_pkg::REG_DATA,    8'h00);  // stale
        issue_cpu_access(vucrp_pkg::CMD_READ,    vucrp_pkg::REG_DATA,    8'h00);
    endtask

    // Walk v from 0x7FE0 through the 16-bit wrap with 32-byte steps, receiver held off first
    task automatic test_vaddr_wrap();
        issue_cpu_access(vucrp_pkg::CMD_READ,  vucrp_pkg::REG_STATUS, 8'h00);
        issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_CTRL,   8'h04);
        issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_ADDR,   8'h3F);
        // second write sets t[14:12]
        issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_SCROLL, 8'hFF);
        issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_SCROLL, 8'hFF);
        issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_ADDR,   8'hE0);  // v = 0x7FE0
        hold_pending = 1'b1;
        for (int i = 0; i < 1040; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_DATA, 8'($urandom));
            end
            else
            begin
                issue_cpu_access(vucrp_pkg::CMD_READ, vucrp_pkg::REG_DATA, 8'($urandom));
            end
        end
    endtask

    // Mostly well-formed register sequences with random content, plus noise
    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          kind;
        int          burst;
        logic [13:0] a;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 32)
            begin
                case ($urandom_range(0, 6))
                    0: a = 14'h0000 + 14'($urandom_range(0, 31));
                    1: a = 14'h1FF0 + 14'($urandom_range(0, 15));
                    2: a = 14'h2000 + 14'($urandom_range(0, 3) * 1024 + $urandom_range(0, 31));
                    3: a = 14'h3000 + 14'($urandom_range(0, 3) * 1024 + $urandom_range(0, 31));
                    4: a = 14'h3EF0 + 14'($urandom_range(0, 15));
                    5: a = 14'h3F00 + 14'($urandom_range(0, 63));
                    default: a = 14'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0)
                begin
                    issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_CTRL, 8'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    issue_cpu_access(vucrp_pkg::CMD_READ, vucrp_pkg::REG_STATUS, 8'($urandom));
                    sent++;
                end
                set_vram_pointer(a, 2'($urandom));
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst; i++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_DATA,
                                         8'($urandom));
                    end
                    else
                    begin
                        issue_cpu_access(vucrp_pkg::CMD_READ, vucrp_pkg::REG_DATA,
                                         8'($urandom));
                    end
                end
                sent += 2 + burst;
            end
            else if (kind < 44)
            begin
                issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_SCROLL, 8'($urandom));
                issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_SCROLL, 8'($urandom));
                sent += 2;
            end
            else if (kind < 58)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_OAMADDR,
                                     8'($urandom_range(0, 7)));
                end
                else
                begin
                    issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_OAMADDR,
                                     8'($urandom_range(250, 255)));
                end
                burst = $urandom_range(1, 6);
                for (int i = 0; i < burst; i++)
                begin
                    issue_cpu_access(vucrp_pkg::cmd_t'(2'($urandom_range(0, 1))),
                                     vucrp_pkg::REG_OAMDATA, 8'($urandom));
                end
                sent += 1 + burst;
            end
            else if (kind < 72)
            begin
                // vblank and NMI interplay
                case ($urandom_range(0, 3))
                    0: issue_cpu_access(vucrp_pkg::CMD_VBL_SET,
                                        vucrp_pkg::reg_idx_t'(3'($urandom)), 8'($urandom));
                    1: issue_cpu_access(vucrp_pkg::CMD_VBL_CLR,
                                        vucrp_pkg::reg_idx_t'(3'($urandom)), 8'($urandom));
                    2: issue_cpu_access(vucrp_pkg::CMD_WRITE, vucrp_pkg::REG_CTRL,
                                        8'($urandom));
                    default: issue_cpu_access(vucrp_pkg::CMD_READ, vucrp_pkg::REG_STATUS,
                                              8'($urandom));
                endcase
                sent++;
            end
            else
            begin
                issue_cpu_access(vucrp_pkg::cmd_t'(2'($urandom)),
                                 vucrp_pkg::reg_idx_t'(3'($urandom)), 8'($urandom));
                sent++;
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        vucrp_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bus_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[7:0], 8'h00);
            end
            else
            begin
                want = pending_bus_results.pop_front();
                if (m_axis_tdata[7:0] !== want.read_data)
                begin
                    report_mismatch("read_data", m_axis_tdata[7:0], want.read_data);
                end
                if (m_axis_tdata[8] !== want.nmi)
                begin
                    report_mismatch("nmi_request", {7'h00, m_axis_tdata[8]}, {7'h00, want.nmi});
                end
            end
        end
    end

    // Result side ready: random stalls, or a long hold when requested
    always @(posedge clk)
    begin
        if (hold_pending)
        begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !(sink_idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog on transaction progress
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("video_unit_cpu_register_port_top_test: errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Sequence of tests
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 5'h00;
        m_axis_tready = 1'b0;
        err_count     = 0;
        stall_cycles  = 0;
        hold_pending  = 1'b0;
        hold_left     = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;

        // shadow state at reset
        mir_horizontal = 1'b0;
        vaddr        = 16'h0000;
        taddr        = 16'h0000;
        fine_x       = 3'd0;
        second_write = 1'b0;
        ctrl_q       = 8'h00;
        mask_q       = 8'h00;
        status_q     = 8'hA0;
        oam_ptr      = 8'h00;
        data_latch   = 8'h00;
        bus_latch    = 8'h00;
        foreach (pal_ram[i]) pal_ram[i] = 8'h00;
        foreach (oam_ram[i]) oam_ram[i] = 8'h00;
        foreach (nt_ram[i])  nt_ram[i]  = 8'h00;
        foreach (chr_ram[i]) chr_ram[i] = 8'h00;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mirroring(1'b0);
        test_register_corners();
        wait_bus_drained();

        // long stretch with no idling on either side
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_mirroring(1'b1);
        test_vaddr_wrap();
        wait_bus_drained();

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int seg = 0; seg < 4; seg++)
        begin
            write_mirroring(seg[0]);
            test_random_traffic(35);
            wait_bus_drained();
        end

        repeat (8) @(posedge clk);
        if (err_count == 0)
        begin
            $display("video_unit_cpu_register_port_top_test: clean");
        end
        else
        begin
            $display("video_unit_cpu_register_port_top_test: errors");
        end
        $finish;
    end

endmodule
